// ===== rtl/wtmp_pkg.sv =====
// Package for the windowed trade microprice block: widths, event kinds, FSM states.
// No dependencies; used by every other file in rtl and by both bench files.
`timescale 1ns / 1ps
package wtmp_pkg;
    localparam int RING_DEPTH = 256;
    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam int CNT_W = IDX_W + 1;
    localparam int DIV_W = 128;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);
    localparam logic [39:0] WINDOW_RESET = 40'd1000000;

    localparam logic [1:0] KIND_BUY = 2'd0;
    localparam logic [1:0] KIND_SELL = 2'd1;
    localparam logic [1:0] KIND_OTHER = 2'd2;
    localparam logic [1:0] KIND_SPARE = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRUNE_RD,
        ST_PRUNE_CHK,
        ST_APPEND,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_DIV,
        ST_ROUND,
        ST_OUT
    } state_t;
endpackage

// ===== rtl/windowed_trade_microprice_top.sv =====
// Top level of the windowed trade microprice block: stream ports and output register.
// Depends on wtmp_pkg and wtmp_core.
`timescale 1ns / 1ps
// Usage: each input transfer on the s_ channel carries one market event. The block
// first drops stored trade slices older than window_us, appends a buy or sell trade
// to a 256-entry ring in a memory with a registered read, then forms the
// volume-weighted microprice exactly: 32-bit squares, 32-bit partial products for
// the numerator and denominator, and a 128-step restoring divider.
// One result transfer on the m_ channel follows every input transfer.
// The divider produces one quotient bit per cycle. A new event is taken only when
// the core is idle and the result register is empty or drained in that cycle, so
// the block never takes an event while the last one is still in flight, and a result
// held by a stalled receiver holds off the next input transfer until it is taken.
// Reset (aresetn low, synchronous) empties the ring, clears all sums and loads
// window_us with 1000000. The cfg channel writes window_us and should be used only
// while the block is idle.
module windowed_trade_microprice_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [39:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [151:0] s_tdata,  // event_time[62:0], price[93:63], amount[117:94],
                                   // mid_price[148:118], zero fill
    input  logic [1:0]   s_tuser,  // kind[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,  // reference_price[30:0], overflow[31]
    output logic         m_tuser   // from_micro
);
    logic [39:0] window_reg;
    logic        busy, done, r_micro, r_ovf;
    logic [30:0] r_price;
    logic        mvalid_reg;
    logic [31:0] mdata_reg;
    logic        muser_reg;

    assign cfg_ready = 1'b1;
    // A new event is accepted only when the output register is empty or being
    // drained, so the core's result always finds the register free.
    assign s_tready = !busy && (!mvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= wtmp_pkg::WINDOW_RESET;
            mvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid) window_reg <= cfg_data;
            if (done) mvalid_reg <= 1'b1;
            else if (m_tready) mvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done) begin
            mdata_reg <= {r_ovf, r_price};
            muser_reg <= r_micro;
        end
    end

    wtmp_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .window_us    (window_reg),
        .start        (s_tvalid && s_tready),
        .kind         (s_tuser),
        .event_time   (s_tdata[62:0]),
        .price        (s_tdata[93:63]),
        .amount       (s_tdata[117:94]),
        .mid_price    (s_tdata[148:118]),
        .busy         (busy),
        .done         (done),
        .res_price    (r_price),
        .res_micro    (r_micro),
        .res_overflow (r_ovf)
    );

    assign m_tvalid = mvalid_reg;
    assign m_tdata = mdata_reg;
    assign m_tuser = muser_reg;
endmodule

// ===== rtl/wtmp_core.sv =====
// Sequencer, slice ring memory, running sums and the serial divider.
// Depends on wtmp_pkg.
`timescale 1ns / 1ps
module wtmp_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [39:0] window_us,
    input  logic        start,
    input  logic [1:0]  kind,
    input  logic [62:0] event_time,
    input  logic [30:0] price,
    input  logic [23:0] amount,
    input  logic [30:0] mid_price,
    output logic        busy,
    output logic        done,
    output logic [30:0] res_price,
    output logic        res_micro,
    output logic        res_overflow
);
    localparam int IW = wtmp_pkg::IDX_W;
    localparam int CW = wtmp_pkg::CNT_W;

    // Slice memory: {side, volume, price*volume, time}.
    localparam int SW = 1 + 24 + 55 + 63;
    logic [SW-1:0] mem [wtmp_pkg::RING_DEPTH];
    logic [SW-1:0] rd_data_reg;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [SW-1:0] wr_data;
    logic [IW-1:0] rd_addr;

    wtmp_pkg::state_t state_reg, state_next;
    logic [IW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [31:0]   vb_reg, vb_next, vs_reg, vs_next;
    logic [62:0]   nb_reg, nb_next, ns_reg, ns_next;
    logic [1:0]    kind_reg;
    logic [62:0]   time_reg;
    logic [30:0]   price_reg, mid_reg;
    logic [23:0]   amount_reg;
    logic          ovf_reg, ovf_next;
    logic          evict_app_reg, evict_app_next;
    logic [63:0]   sq_a_reg, sq_b_reg, vbs_reg;
    logic [127:0]  num_reg, den_reg, rem_reg;
    logic [63:0]   q_reg;
    logic [wtmp_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic [1:0]    part_reg;
    logic [30:0]   res_price_reg;
    logic          res_micro_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    logic          s_side;
    logic [23:0]   s_vol;
    logic [54:0]   s_pv;
    logic [62:0]   s_time;
    logic [62:0]   age;
    logic          is_trade;
    logic          full;
    assign {s_side, s_vol, s_pv, s_time} = rd_data_reg;
    assign age = (time_reg >= s_time) ? time_reg - s_time : 63'd0;
    assign is_trade = (kind_reg == wtmp_pkg::KIND_BUY) || (kind_reg == wtmp_pkg::KIND_SELL);
    assign full = (count_reg == CW'(wtmp_pkg::RING_DEPTH));
    assign rd_addr = head_reg;

    logic [54:0] pv_new;
    assign pv_new = 55'(price_reg) * 55'(amount_reg);

    // Divider step.
    logic [128:0] rem_sh;
    logic         take;
    assign rem_sh = {rem_reg, num_reg[127]};
    assign take = rem_sh >= {1'b0, den_reg};

    // Wide products are built from 32-bit halves, one numerator partial product per cycle.
    // part_reg picks the halves; the partial lands at 32 times the sum of its half indexes.
    logic [31:0]  mul_x, mul_y;
    logic [63:0]  mul_p;
    logic [1:0]   mul_pos;
    logic [127:0] mul_term;
    logic [32:0]  vol_sum;
    logic [64:0]  den_p;
    logic [127:0] den_term;
    assign mul_x = (state_reg == wtmp_pkg::ST_MUL3)
                 ? (part_reg[1] ? {1'b0, ns_reg[62:32]} : ns_reg[31:0])
                 : (part_reg[1] ? {1'b0, nb_reg[62:32]} : nb_reg[31:0]);
    assign mul_y = (state_reg == wtmp_pkg::ST_MUL3)
                 ? (part_reg[0] ? sq_b_reg[63:32] : sq_b_reg[31:0])
                 : (part_reg[0] ? sq_a_reg[63:32] : sq_a_reg[31:0]);
    assign mul_p = 64'(mul_x) * 64'(mul_y);
    assign mul_pos = {1'b0, part_reg[1]} + {1'b0, part_reg[0]};
    assign mul_term = 128'(mul_p) << {mul_pos, 5'd0};
    assign vol_sum = 33'(vb_reg) + 33'(vs_reg);
    assign den_p = 65'(part_reg[0] ? vbs_reg[63:32] : vbs_reg[31:0]) * 65'(vol_sum);
    assign den_term = 128'(den_p) << {part_reg[0], 5'd0};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            wtmp_pkg::ST_IDLE:      if (start) state_next = wtmp_pkg::ST_PRUNE_RD;
            wtmp_pkg::ST_PRUNE_RD:  state_next = (count_reg != '0) ? wtmp_pkg::ST_PRUNE_CHK
                                                               : wtmp_pkg::ST_APPEND;
            wtmp_pkg::ST_PRUNE_CHK: state_next = (age > 63'(window_us)) ? wtmp_pkg::ST_PRUNE_RD
                                                                    : wtmp_pkg::ST_APPEND;
            wtmp_pkg::ST_APPEND:    state_next = (is_trade && full && !evict_app_reg)
                                                 ? wtmp_pkg::ST_APPEND : wtmp_pkg::ST_MUL1;
            wtmp_pkg::ST_MUL1:      state_next = wtmp_pkg::ST_MUL2;
            wtmp_pkg::ST_MUL2:      if (&part_reg) state_next = wtmp_pkg::ST_MUL3;
            wtmp_pkg::ST_MUL3:      if (&part_reg) state_next = wtmp_pkg::ST_DIV;
            wtmp_pkg::ST_DIV:       if (div_cnt_reg == '0) state_next = wtmp_pkg::ST_ROUND;
            wtmp_pkg::ST_ROUND:     state_next = wtmp_pkg::ST_OUT;
            wtmp_pkg::ST_OUT:       state_next = wtmp_pkg::ST_IDLE;
            default:                state_next = wtmp_pkg::ST_IDLE;
        endcase
    end

    // Evict or append: sum and ring bookkeeping.
    logic do_evict;
    always_comb begin
        head_next = head_reg;
        count_next = count_reg;
        vb_next = vb_reg;
        vs_next = vs_reg;
        nb_next = nb_reg;
        ns_next = ns_reg;
        ovf_next = ovf_reg;
        evict_app_next = evict_app_reg;
        wr_en = 1'b0;
        wr_addr = IW'(head_reg + count_reg[IW-1:0]);
        wr_data = {kind_reg[0], amount_reg, pv_new, time_reg};
        do_evict = 1'b0;
        case (state_reg)
            wtmp_pkg::ST_IDLE: begin
                ovf_next = 1'b0;
                evict_app_next = 1'b0;
            end
            wtmp_pkg::ST_PRUNE_CHK: do_evict = (age > 63'(window_us));
            wtmp_pkg::ST_APPEND: begin
                if (is_trade && full && !evict_app_reg) begin
                    // Head entry was read in prune; rd_data_reg still holds it.
                    do_evict = 1'b1;
                    ovf_next = 1'b1;
                    evict_app_next = 1'b1;
                end else if (is_trade) begin
                    wr_en = 1'b1;
                    count_next = count_reg + 1'b1;
                    if (kind_reg[0]) begin
                        vs_next = vs_reg + 32'(amount_reg);
                        ns_next = ns_reg + 63'(pv_new);
                    end else begin
                        vb_next = vb_reg + 32'(amount_reg);
                        nb_next = nb_reg + 63'(pv_new);
                    end
                end
            end
            default: ;
        endcase
        if (do_evict) begin
            head_next = head_reg + 1'b1;
            count_next = count_reg - 1'b1;
            if (s_side) begin
                vs_next = vs_reg - 32'(s_vol);
                ns_next = ns_reg - 63'(s_pv);
            end else begin
                vb_next = vb_reg - 32'(s_vol);
                nb_next = nb_reg - 63'(s_pv);
            end
        end
    end

    // When the ring is full after pruning, the head entry must be current in rd_data_reg.
    // Pruning always reads the head before reaching APPEND when count is nonzero.

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wtmp_pkg::ST_IDLE;
            head_reg <= '0;
            count_reg <= '0;
            vb_reg <= '0;
            vs_reg <= '0;
            nb_reg <= '0;
            ns_reg <= '0;
            ovf_reg <= 1'b0;
            evict_app_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg <= head_next;
            count_reg <= count_next;
            vb_reg <= vb_next;
            vs_reg <= vs_next;
            nb_reg <= nb_next;
            ns_reg <= ns_next;
            ovf_reg <= ovf_next;
            evict_app_reg <= evict_app_next;
        end
    end

    // Payload path: event capture, squares, numerator and denominator from partial
    // products, then 128 divide steps and rounding with the mid-price fallback.
    always_ff @(posedge aclk) begin
        case (state_reg)
            wtmp_pkg::ST_IDLE: if (start) begin
                kind_reg <= kind;
                time_reg <= event_time;
                price_reg <= price;
                amount_reg <= amount;
                mid_reg <= mid_price;
            end
            wtmp_pkg::ST_MUL1: begin
                sq_a_reg <= 64'(vs_reg) * 64'(vs_reg);
                sq_b_reg <= 64'(vb_reg) * 64'(vb_reg);
                vbs_reg <= 64'(vb_reg) * 64'(vs_reg);
                num_reg <= '0;
                den_reg <= '0;
                part_reg <= '0;
            end
            wtmp_pkg::ST_MUL2: begin
                num_reg <= num_reg + mul_term;
                if (!part_reg[1]) den_reg <= den_reg + den_term;
                part_reg <= part_reg + 1'b1;
            end
            wtmp_pkg::ST_MUL3: begin
                num_reg <= num_reg + mul_term;
                part_reg <= part_reg + 1'b1;
                rem_reg <= '0;
                q_reg <= '0;
                div_cnt_reg <= wtmp_pkg::DIV_CNT_W'(wtmp_pkg::DIV_W);
            end
            wtmp_pkg::ST_DIV: if (div_cnt_reg != '0) begin
                rem_reg <= take ? 128'(rem_sh - {1'b0, den_reg}) : rem_sh[127:0];
                q_reg <= {q_reg[62:0], take};
                num_reg <= {num_reg[126:0], 1'b0};
                div_cnt_reg <= div_cnt_reg - 1'b1;
            end
            wtmp_pkg::ST_ROUND: begin
                if (vb_reg != '0 && vs_reg != '0 && den_reg != '0 &&
                    (q_reg + 64'({rem_reg, 1'b0} >= {1'b0, den_reg})) != '0) begin
                    res_price_reg <= 31'(q_reg + 64'({rem_reg, 1'b0} >= {1'b0, den_reg}));
                    res_micro_reg <= 1'b1;
                end else begin
                    res_price_reg <= mid_reg;
                    res_micro_reg <= 1'b0;
                end
            end
            default: ;
        endcase
    end

    assign busy = (state_reg != wtmp_pkg::ST_IDLE);
    assign done = (state_reg == wtmp_pkg::ST_OUT);
    assign res_price = res_price_reg;
    assign res_micro = res_micro_reg;
    assign res_overflow = ovf_reg;
endmodule

// ===== bench/microprice_checker.sv =====
// Checker for the windowed trade microprice block: watches the cfg, s_ and m_ channels,
// predicts every result with its own slice ring and sums, and counts mismatches.
// Depends on wtmp_pkg.
`timescale 1ns / 1ps
module microprice_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [39:0]  cfg_data,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [151:0] s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [31:0]  m_tdata,
    input  logic         m_tuser,
    output int           fail_count,
    output int           pending_count,
    output int           price_results,
    output int           overflow_results
);
    localparam int FIFO_DEPTH = 16;

    typedef struct packed {
        logic [30:0] ref_price;
        logic        micro;
        logic        ovf;
    } quote_t;

    logic [39:0]  window_q;
    logic [62:0]  trade_time [wtmp_pkg::RING_DEPTH];
    logic         trade_sell [wtmp_pkg::RING_DEPTH];
    logic [23:0]  trade_vol  [wtmp_pkg::RING_DEPTH];
    logic [54:0]  trade_pv   [wtmp_pkg::RING_DEPTH];
    int           oldest;
    int           held;
    logic [63:0]  buy_vol, sell_qty, buy_not, sell_not;
    quote_t       quote_fifo [FIFO_DEPTH];
    int           fifo_wr, fifo_rd;

    // Removes the oldest slice from the ring and its side's sums.
    task automatic drop_oldest();
        if (trade_sell[oldest]) begin
            sell_qty -= trade_vol[oldest];
            sell_not -= trade_pv[oldest];
        end else begin
            buy_vol -= trade_vol[oldest];
            buy_not -= trade_pv[oldest];
        end
        oldest = (oldest + 1) % wtmp_pkg::RING_DEPTH;
        held--;
    endtask

    // Exact rounded-half-up microprice; returns 0 when it is undefined or zero.
    function automatic logic [63:0] microprice_of();
        logic [127:0] num, den, q, r;
        if (buy_vol == 0 || sell_qty == 0) return 64'd0;
        num = 128'(buy_not) * 128'(64'(sell_qty * sell_qty))
            + 128'(sell_not) * 128'(64'(buy_vol * buy_vol));
        den = 128'(64'(buy_vol * sell_qty)) * 128'(64'(buy_vol + sell_qty));
        if (den == 0) return 64'd0;
        q = num / den;
        r = num % den;
        if ({r, 1'b0} >= {1'b0, den}) q++;
        return q[63:0];
    endfunction

    task automatic predict_event(input logic [1:0] kind, input logic [151:0] d);
        logic [62:0] now;
        logic [63:0] age, mp;
        int          tail;
        quote_t      qt;
        now = d[62:0];
        qt = '0;
        while (held > 0) begin
            age = (now >= trade_time[oldest]) ? 64'(now - trade_time[oldest]) : 64'd0;
            if (age <= 64'(window_q)) break;
            drop_oldest();
        end
        if (kind == wtmp_pkg::KIND_BUY || kind == wtmp_pkg::KIND_SELL) begin
            if (held >= wtmp_pkg::RING_DEPTH) begin
                drop_oldest();
                qt.ovf = 1'b1;
            end
            tail = (oldest + held) % wtmp_pkg::RING_DEPTH;
            trade_time[tail] = now;
            trade_sell[tail] = (kind == wtmp_pkg::KIND_SELL);
            trade_vol[tail]  = d[117:94];
            trade_pv[tail]   = 55'(d[93:63]) * 55'(d[117:94]);
            held++;
            if (kind == wtmp_pkg::KIND_BUY) begin
                buy_vol += d[117:94];
                buy_not += trade_pv[tail];
            end else begin
                sell_qty += d[117:94];
                sell_not += trade_pv[tail];
            end
        end
        mp = microprice_of();
        if (mp != 0) begin
            qt.ref_price = mp[30:0];
            qt.micro = 1'b1;
        end else begin
            qt.ref_price = d[148:118];
        end
        quote_fifo[fifo_wr % FIFO_DEPTH] = qt;
        fifo_wr++;
    endtask

    always @(posedge aclk) begin
        quote_t qt;
        int     errs;
        errs = 0;
        if (!aresetn) begin
            window_q <= wtmp_pkg::WINDOW_RESET;
            oldest = 0;
            held = 0;
            buy_vol = 0;
            sell_qty = 0;
            buy_not = 0;
            sell_not = 0;
            fifo_wr = 0;
            fifo_rd = 0;
            fail_count <= 0;
            price_results <= 0;
            overflow_results <= 0;
        end else begin
            if (cfg_valid && cfg_ready) window_q <= cfg_data;
            if (m_tvalid && m_tready) begin
                if (fifo_wr == fifo_rd) begin
                    $error("unexpected result transfer: %h", m_tdata);
                    errs++;
                end else begin
                    qt = quote_fifo[fifo_rd % FIFO_DEPTH];
                    fifo_rd++;
                    if (m_tdata[30:0] !== qt.ref_price) begin
                        $error("reference_price: expected %0d, actual %0d",
                               qt.ref_price, m_tdata[30:0]);
                        errs++;
                    end
                    if (m_tuser !== qt.micro) begin
                        $error("from_micro: expected %0d, actual %0d", qt.micro, m_tuser);
                        errs++;
                    end
                    if (m_tdata[31] !== qt.ovf) begin
                        $error("overflow: expected %0d, actual %0d", qt.ovf, m_tdata[31]);
                        errs++;
                    end
                    price_results <= price_results + qt.micro;
                    overflow_results <= overflow_results + qt.ovf;
                end
            end
            if (s_tvalid && s_tready) predict_event(s_tuser, s_tdata);
            fail_count <= fail_count + errs;
        end
        pending_count <= fifo_wr - fifo_rd;
    end
endmodule

// ===== bench/tb_top.sv =====
// Testbench top for the windowed trade microprice block: drives clock, reset, window
// writes and market events, and gives the verdict. Depends on wtmp_pkg, the block and
// microprice_checker.
`timescale 1ns / 1ps
module tb_top;
    localparam int STALL_LIMIT = 20000;
    localparam int RANDOM_EVENTS = 1750;

    logic         aclk;
    logic         aresetn;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [39:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [151:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;
    logic         m_tuser;
    int           fail_count, pending_count, price_results, overflow_results;

    // Idle percentages for the sender and the receiver in the current phase.
    int           send_idle_pct;
    int           recv_idle_pct;
    int           quiet_cycles;
    int           sent_events;
    logic [62:0]  clock_us;

    windowed_trade_microprice_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    microprice_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending_count(pending_count),
        .price_results(price_results), .overflow_results(overflow_results)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    // The receiver stalls at random with the phase's percentage, on every cycle.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: the run ends as failed when no transfer happens for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("** windowed_trade_microprice_top: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Sends one event; the sender may first idle for some cycles.
    task automatic send_event(input logic [1:0] kind, input logic [62:0] when,
                              input logic [30:0] price, input logic [23:0] amount,
                              input logic [30:0] mid);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {3'b0, mid, amount, price, when};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_events++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
    endtask

    // Writes window_us once every expected result has come back.
    task automatic write_window(input logic [39:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // A random trade or other event with time moving mostly forward.
    task automatic random_event(input int step_max);
        logic [1:0]  kind;
        logic [30:0] price;
        logic [23:0] amount;
        int          pick;
        pick = $urandom_range(99);
        kind = (pick < 45) ? wtmp_pkg::KIND_BUY : (pick < 90) ? wtmp_pkg::KIND_SELL :
               ($urandom_range(1) == 0) ? wtmp_pkg::KIND_OTHER : wtmp_pkg::KIND_SPARE;
        if ($urandom_range(19) == 0) begin
            price = 31'($urandom());
            amount = 24'($urandom());
        end else begin
            price = 31'($urandom_range(900, 1100));
            amount = 24'($urandom_range(0, 5000));
        end
        if ($urandom_range(49) == 0) clock_us = clock_us - 63'($urandom_range(step_max));
        else clock_us = clock_us + 63'($urandom_range(step_max));
        send_event(kind, clock_us, price, amount, 31'($urandom()));
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = wtmp_pkg::KIND_BUY;
        sent_events = 0;
        send_idle_pct = 15;
        recv_idle_pct = 72;
        clock_us = 63'd5;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: empty sums, one-sided sums, field extremes, zero amount,
        // the spare kind code, time running backwards and a full window reset.
        send_event(wtmp_pkg::KIND_OTHER, 63'd0, 31'd0, 24'd0, 31'h7fffffff);
        send_event(wtmp_pkg::KIND_BUY, 63'd10, 31'h7fffffff, 24'hffffff, 31'd0);
        send_event(wtmp_pkg::KIND_SPARE, 63'd11, 31'd5, 24'd5, 31'd77);
        send_event(wtmp_pkg::KIND_SELL, 63'd12, 31'd1, 24'd0, 31'd123);
        send_event(wtmp_pkg::KIND_SELL, 63'd13, 31'd0, 24'hffffff, 31'd9);
        send_event(wtmp_pkg::KIND_SELL, 63'd14, 31'd1000, 24'd1, 31'd9);
        send_event(wtmp_pkg::KIND_BUY, 63'd8, 31'd1001, 24'd3, 31'd9);
        send_event(wtmp_pkg::KIND_BUY, 63'h7fffffffffffffff, 31'd2, 24'd1, 31'd44);
        send_event(wtmp_pkg::KIND_SELL, 63'h7fffffffffffffff, 31'd3, 24'd1, 31'd44);
        send_event(wtmp_pkg::KIND_BUY, 63'd0, 31'd7, 24'd2, 31'h55555555);
        write_window(40'd0);
        send_event(wtmp_pkg::KIND_BUY, 63'h7fffffffffffffff, 31'd0, 24'd1, 31'h2aaaaaaa);
        send_event(wtmp_pkg::KIND_SELL, 63'h7fffffffffffffff, 31'h7fffffff, 24'd7, 31'd1);
        send_event(wtmp_pkg::KIND_OTHER, 63'h7ffffffffffffffe, 31'd0, 24'd0, 31'd1);
        write_window(40'hffffffffff);

        // Random part in three idling phases; the window alternates between
        // wide values that fill and overflow the ring and narrow ones that prune.
        clock_us = 63'd1000;
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 72 : 0;
            recv_idle_pct = (phase == 0) ? 72 : (phase == 1) ? 15 : 0;
            for (int n = 0; n < RANDOM_EVENTS / 3; n++) begin
                if (n % 150 == 0) begin
                    case ((n / 150 + phase) % 4)
                        0: write_window(40'hffffffffff);
                        1: write_window(40'd1000000);
                        2: write_window(40'($urandom_range(0, 300)));
                        default: write_window(40'($urandom_range(1000, 50000)));
                    endcase
                end
                random_event((n / 150) % 2 ? 400 : 40);
            end
        end
        drain();
        repeat (300) @(posedge aclk);

        $display("Run covered %0d events, %0d microprice results, %0d early evictions.",
                 sent_events, price_results, overflow_results);
        $display("Window values ranged from zero to the 40-bit maximum over three stall mixes.");
        if (fail_count == 0) begin
            $display("** windowed_trade_microprice_top: PASSED **");
        end else begin
            $display("** windowed_trade_microprice_top: FAILED **");
        end
        $finish;
    end
endmodule

// ===== windowed_trade_microprice_top.f =====
rtl/wtmp_pkg.sv
rtl/wtmp_core.sv
rtl/windowed_trade_microprice_top.sv
bench/microprice_checker.sv
bench/tb_top.sv
